// ===== rtl/motor_command_frame_parser_defines.svh =====
// assertion helpers for the parser rtl
// all of them expect clk and rst_n in the scope where they are used
`ifndef MOTOR_COMMAND_FRAME_PARSER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_PARSER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MCFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfp_pkg
// Types and constants of the motor command frame parser.
// ----------------------------------------------------------------------------
package mcfp_pkg;

    localparam int NAME_MAX    = 9;
    localparam int LEN_W       = $clog2(NAME_MAX + 2);
    localparam int NUM_NAMES   = 6;
    localparam int KNOWN_CHARS = 9;
    localparam int CMP_N       = (NAME_MAX < KNOWN_CHARS) ? NAME_MAX : KNOWN_CHARS;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    typedef enum logic [2:0] {
        ST_MOTOR1    = 3'd0,
        ST_MOTOR2    = 3'd1,
        ST_SERVO1    = 3'd2,
        ST_SERVO2    = 3'd3,
        ST_ESTOP     = 3'd4,
        ST_CONNECTED = 3'd5,
        ST_MALFORMED = 3'd6,
        ST_UNKNOWN   = 3'd7
    } status_t;

    typedef enum logic {
        REG_DEADBAND   = 1'b0,
        REG_SERVO_MAX  = 1'b1
    } reg_idx_t;

    // names are left justified, first character in element 0
    typedef logic [0:KNOWN_CHARS-1][7:0] known_name_t;

    localparam known_name_t KNOWN_NAMES [NUM_NAMES] = '{
        {"M1", 56'h0},
        {"M2", 56'h0},
        {"S1", 56'h0},
        {"S2", 56'h0},
        {"estop", 32'h0},
        {"connected"}
    };
    localparam int KNOWN_LEN [NUM_NAMES] = '{2, 2, 2, 2, 5, 9};

    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_N     = 8'h6E;

    localparam logic [7:0] DEADBAND_RST  = 8'd5;
    localparam logic [7:0] SERVO_MAX_RST = 8'd180;

    typedef struct packed {
        status_t     status;
        logic        motor_reverse;
        logic [7:0]  motor_duty;
        logic [7:0]  servo_angle;
        logic        estop_on;
        logic [16:0] battery_value;
        logic        value_saturated;
        logic        frame_end;
    } result_t;

endpackage

// ===== rtl/motor_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_parser
// Byte-wise parser of bracketed motor/servo command frames.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_ready) carries one received byte plus the
//   current battery reading; output channel (out_valid/out_ready) carries
//   one decoded item each time a ',' or ']' ends an item.
//   the apb port holds deadband (addr 0) and servo_max_angle (addr 4); the
//   user must write it only while the block is idle; the block does not enforce this.
// Throughput and timing:
//   one byte is accepted per cycle while the output is not stalled; a result
//   appears in the output register in the cycle after its terminating byte is accepted. per-byte work is one
//   pass of the parse logic between the state registers and the result
//   register.
// Stall:
//   while a result waits in the output register and out_ready is low, no
//   new byte is accepted; when the result is taken a new byte is accepted
//   in the same cycle.
// Reset:
//   rst_n clears the parse state to the start of a frame, empties the output
//   register and restores deadband 5 and servo_max_angle 180.
// ----------------------------------------------------------------------------
`include "motor_command_frame_parser_defines.svh"

module motor_command_frame_parser (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    input  logic [11:0]                 battery_sample,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic                        motor_reverse,
    output logic [7:0]                  motor_duty,
    output logic [7:0]                  servo_angle,
    output logic                        estop_on,
    output logic [16:0]                 battery_value,
    output logic                        value_saturated,
    output logic                        frame_end,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mcfp_pkg::ADDR_W-1:0] paddr,
    input  logic [mcfp_pkg::DATA_W-1:0] pwdata,
    output logic [mcfp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ON_NONE = 2'd0,
        ON_O    = 2'd1,
        ON_ON   = 2'd2,
        ON_FAIL = 2'd3
    } on_t;

    // configuration
    logic [7:0] deadband_reg;
    logic [7:0] servo_max_reg;

    // parse state
    logic                           at_frame_start_reg;
    logic [7:0]                     name_chars_reg [mcfp_pkg::NAME_MAX];
    logic [mcfp_pkg::LEN_W-1:0]     name_length_reg;
    logic                           seen_colon_reg;
    phase_t                         parse_phase_reg;
    logic                           value_negative_reg;
    logic [15:0]                    value_magnitude_reg;
    on_t                            on_match_reg;

    logic                           out_valid_reg;
    mcfp_pkg::result_t              res_reg;

    logic                           in_acc;
    logic                           is_close;
    logic                           is_comma;
    logic                           is_digit;
    logic                           is_space;
    logic                           is_sign;
    logic                           has_result;
    logic                           name_wr;
    logic                           value_wr;

    phase_t                         parse_phase_next;
    on_t                            on_match_next;
    logic [15:0]                    value_magnitude_next;
    logic [19:0]                    mag_times10;

    mcfp_pkg::result_t              res_next;
    logic [mcfp_pkg::NUM_NAMES-1:0] hit;
    logic [15:0]                    mag_clip;
    logic                           clip_sat;
    logic                           reverse;
    logic [17:0]                    batt_x45;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    assign is_close = (rx_byte == mcfp_pkg::CH_CLOSE);
    assign is_comma = (rx_byte == mcfp_pkg::CH_COMMA);
    assign is_digit = (rx_byte >= mcfp_pkg::CH_ZERO) && (rx_byte <= mcfp_pkg::CH_NINE);
    assign is_space = (rx_byte == mcfp_pkg::CH_SPACE) || ((rx_byte >= 8'd9) && (rx_byte <= 8'd13));
    assign is_sign  = (rx_byte == mcfp_pkg::CH_PLUS) || (rx_byte == mcfp_pkg::CH_MINUS);

    assign has_result = is_close || (!at_frame_start_reg && is_comma);
    assign name_wr    = !is_close && !at_frame_start_reg && !is_comma && !seen_colon_reg
                        && (rx_byte != mcfp_pkg::CH_COLON);
    assign value_wr   = !is_close && !at_frame_start_reg && !is_comma && seen_colon_reg;

    // value byte: "on" matcher, atol phase and saturating accumulate
    assign mag_times10 = {1'b0, value_magnitude_reg, 3'b000}
                         + {3'b000, value_magnitude_reg, 1'b0}
                         + {12'd0, rx_byte - mcfp_pkg::CH_ZERO};

    always_comb
    begin
        unique case (on_match_reg)
            ON_NONE: on_match_next = (rx_byte == mcfp_pkg::CH_O) ? ON_O : ON_FAIL;
            ON_O:    on_match_next = (rx_byte == mcfp_pkg::CH_N) ? ON_ON : ON_FAIL;
            default: on_match_next = ON_FAIL;
        endcase

        unique case (parse_phase_reg)
            PH_SPACE:
            begin
                if (is_space)
                    parse_phase_next = PH_SPACE;
                else if (is_sign)
                    parse_phase_next = PH_SIGN;
                else
                    parse_phase_next = is_digit ? PH_DIGITS : PH_DONE;
            end
            PH_SIGN, PH_DIGITS:
                parse_phase_next = is_digit ? PH_DIGITS : PH_DONE;
            default:
                parse_phase_next = PH_DONE;
        endcase

        value_magnitude_next = value_magnitude_reg;
        if (is_digit && (parse_phase_reg != PH_DONE))
            value_magnitude_next = (mag_times10 > 20'd65535) ? 16'hFFFF : mag_times10[15:0];
    end

    // item finish, evaluated on the state before the terminating byte
    assign batt_x45 = 18'(battery_sample) * 18'd45;

    always_comb
    begin
        for (int k = 0; k < mcfp_pkg::NUM_NAMES; k++)
        begin
            hit[k] = (int'(name_length_reg) == mcfp_pkg::KNOWN_LEN[k])
                     && (mcfp_pkg::KNOWN_LEN[k] <= mcfp_pkg::NAME_MAX);
            for (int i = 0; i < mcfp_pkg::CMP_N; i++)
            begin
                if ((i < mcfp_pkg::KNOWN_LEN[k])
                    && (name_chars_reg[i] != mcfp_pkg::KNOWN_NAMES[k][i]))
                    hit[k] = 1'b0;
            end
        end

        // clip to the signed 16-bit range
        if (value_negative_reg)
        begin
            clip_sat = (value_magnitude_reg > 16'd32768);
            mag_clip = clip_sat ? 16'd32768 : value_magnitude_reg;
        end
        else
        begin
            clip_sat = (value_magnitude_reg > 16'd32767);
            mag_clip = clip_sat ? 16'd32767 : value_magnitude_reg;
        end

        // deadband forces speed to zero, which drives forward
        reverse = value_negative_reg && (mag_clip != 16'd0)
                  && (mag_clip >= {8'd0, deadband_reg});

        res_next = '0;
        res_next.frame_end = is_close;
        if (!seen_colon_reg)
            res_next.status = mcfp_pkg::ST_MALFORMED;
        else if (hit == '0)
            res_next.status = mcfp_pkg::ST_UNKNOWN;
        else if (hit[0] || hit[1])
        begin
            res_next.status = hit[0] ? mcfp_pkg::ST_MOTOR1 : mcfp_pkg::ST_MOTOR2;
            if (mag_clip < {8'd0, deadband_reg})
            begin
                res_next.motor_duty      = 8'd0;
                res_next.value_saturated = clip_sat;
            end
            else if (reverse)
            begin
                res_next.motor_reverse   = 1'b1;
                res_next.motor_duty      = (mag_clip > 16'd255) ? 8'd0 : 8'd255 - mag_clip[7:0];
                res_next.value_saturated = clip_sat || (mag_clip > 16'd255);
            end
            else
            begin
                res_next.motor_duty      = (mag_clip > 16'd255) ? 8'd255 : mag_clip[7:0];
                res_next.value_saturated = clip_sat || (mag_clip > 16'd255);
            end
        end
        else if (hit[2] || hit[3])
        begin
            res_next.status = hit[2] ? mcfp_pkg::ST_SERVO1 : mcfp_pkg::ST_SERVO2;
            if (value_negative_reg && (mag_clip != 16'd0))
            begin
                res_next.servo_angle     = 8'd0;
                res_next.value_saturated = 1'b1;
            end
            else if (mag_clip > {8'd0, servo_max_reg})
            begin
                res_next.servo_angle     = servo_max_reg;
                res_next.value_saturated = 1'b1;
            end
            else
            begin
                res_next.servo_angle     = mag_clip[7:0];
                res_next.value_saturated = clip_sat;
            end
        end
        else if (hit[4])
        begin
            res_next.status   = mcfp_pkg::ST_ESTOP;
            res_next.estop_on = (on_match_reg == ON_ON);
        end
        else
        begin
            res_next.status        = mcfp_pkg::ST_CONNECTED;
            res_next.battery_value = batt_x45[17:1];
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_frame_start_reg  <= 1'b1;
            name_length_reg     <= '0;
            seen_colon_reg      <= 1'b0;
            parse_phase_reg     <= PH_SPACE;
            value_negative_reg  <= 1'b0;
            value_magnitude_reg <= '0;
            on_match_reg        <= ON_NONE;
            for (int i = 0; i < mcfp_pkg::NAME_MAX; i++)
                name_chars_reg[i] <= '0;
        end
        else if (in_acc)
        begin
            if (is_close || (!at_frame_start_reg && is_comma))
            begin
                at_frame_start_reg  <= is_close;
                name_length_reg     <= '0;
                seen_colon_reg      <= 1'b0;
                parse_phase_reg     <= PH_SPACE;
                value_negative_reg  <= 1'b0;
                value_magnitude_reg <= '0;
                on_match_reg        <= ON_NONE;
            end
            else if (at_frame_start_reg)
                at_frame_start_reg <= 1'b0;
            else if (!seen_colon_reg && (rx_byte == mcfp_pkg::CH_COLON))
                seen_colon_reg <= 1'b1;
            else if (name_wr)
            begin
                // chars past the limit only count toward the length
                for (int i = 0; i < mcfp_pkg::NAME_MAX; i++)
                begin
                    if (name_length_reg == mcfp_pkg::LEN_W'(i))
                        name_chars_reg[i] <= rx_byte;
                end
                if (name_length_reg <= mcfp_pkg::LEN_W'(mcfp_pkg::NAME_MAX))
                    name_length_reg <= name_length_reg + 1'b1;
            end
            else if (value_wr)
            begin
                on_match_reg        <= on_match_next;
                parse_phase_reg     <= parse_phase_next;
                value_magnitude_reg <= value_magnitude_next;
                if ((parse_phase_reg == PH_SPACE) && is_sign)
                    value_negative_reg <= (rx_byte == mcfp_pkg::CH_MINUS);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_acc && has_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && has_result)
            res_reg <= res_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= mcfp_pkg::DEADBAND_RST;
            servo_max_reg <= mcfp_pkg::SERVO_MAX_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (mcfp_pkg::reg_idx_t'(paddr[2]))
                mcfp_pkg::REG_DEADBAND:  deadband_reg  <= pwdata[7:0];
                mcfp_pkg::REG_SERVO_MAX: servo_max_reg <= pwdata[7:0];
                default:                 deadband_reg  <= deadband_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (mcfp_pkg::reg_idx_t'(paddr[2]))
            mcfp_pkg::REG_DEADBAND:  prdata = {24'd0, deadband_reg};
            mcfp_pkg::REG_SERVO_MAX: prdata = {24'd0, servo_max_reg};
            default:                 prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign out_valid       = out_valid_reg;
    assign status          = res_reg.status;
    assign motor_reverse   = res_reg.motor_reverse;
    assign motor_duty      = res_reg.motor_duty;
    assign servo_angle     = res_reg.servo_angle;
    assign estop_on        = res_reg.estop_on;
    assign battery_value   = res_reg.battery_value;
    assign value_saturated = res_reg.value_saturated;
    assign frame_end       = res_reg.frame_end;

    // checks
    `MCFP_ASSERT_NEXT(a_close_ends_frame, in_acc && is_close, at_frame_start_reg && out_valid_reg && res_reg.frame_end, "closing bracket did not end the frame")
    `MCFP_ASSERT_NOW(a_frame_start_clean, at_frame_start_reg, (name_length_reg == '0) && !seen_colon_reg, "item state not clear at frame start")
    `MCFP_ASSERT_NOW(a_estop_stops, out_valid_reg && (res_reg.status == mcfp_pkg::ST_ESTOP), (res_reg.motor_duty == 8'd0) && !res_reg.motor_reverse, "estop result drives a motor")
    `MCFP_ASSERT_NOW(a_servo_clamped, out_valid_reg && ((res_reg.status == mcfp_pkg::ST_SERVO1) || (res_reg.status == mcfp_pkg::ST_SERVO2)), res_reg.servo_angle <= servo_max_reg, "servo angle above limit")
    `MCFP_ASSERT_NOW(a_bad_item_quiet, out_valid_reg && ((res_reg.status == mcfp_pkg::ST_MALFORMED) || (res_reg.status == mcfp_pkg::ST_UNKNOWN)), (res_reg.motor_duty == 8'd0) && !res_reg.value_saturated && (res_reg.battery_value == '0), "bad item carries payload")

endmodule

// ===== dv/mcfp_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfp_scoreboard_pkg
// Byte-level decoder of command frames that mirrors the parser and keeps
// the queue of decoded items still to come out of the block.
// ----------------------------------------------------------------------------
package mcfp_scoreboard_pkg;

    import mcfp_pkg::*;

    class frame_scoreboard;

        typedef enum {PH_SPACE, PH_SIGN, PH_DIGITS, PH_DONE} value_phase_t;
        typedef enum {ON_NONE, ON_O, ON_EXACT, ON_NOT} on_state_t;

        string known [NUM_NAMES] = '{"M1", "M2", "S1", "S2", "estop", "connected"};

        logic [7:0]   deadband;
        logic [7:0]   servo_max;

        bit           at_start;
        logic [7:0]   name_buf [NAME_MAX];
        int unsigned  name_len;
        bit           colon_seen;
        value_phase_t phase;
        bit           negative;
        int unsigned  magnitude;
        on_state_t    on_state;

        result_t      awaited_items [$];
        int unsigned  errors;

        function new();
            deadband  = DEADBAND_RST;
            servo_max = SERVO_MAX_RST;
            at_start  = 1'b1;
            errors    = 0;
            clear_item();
        endfunction

        function void clear_item();
            foreach (name_buf[i])
                name_buf[i] = 8'h00;
            name_len   = 0;
            colon_seen = 1'b0;
            phase      = PH_SPACE;
            negative   = 1'b0;
            magnitude  = 0;
            on_state   = ON_NONE;
        endfunction

        function void set_reg(reg_idx_t idx, logic [7:0] val);
            case (idx)
                REG_DEADBAND:  deadband  = val;
                REG_SERVO_MAX: servo_max = val;
            endcase
        endfunction

        function status_t match_name();
            bit same;
            if (name_len > NAME_MAX)
                return ST_UNKNOWN;
            for (int k = 0; k < NUM_NAMES; k++) begin
                if (known[k].len() != name_len || known[k].len() > NAME_MAX)
                    continue;
                same = 1'b1;
                for (int i = 0; i < known[k].len(); i++)
                    if (name_buf[i] != known[k][i])
                        same = 1'b0;
                if (same)
                    case (k)
                        0: return ST_MOTOR1;
                        1: return ST_MOTOR2;
                        2: return ST_SERVO1;
                        3: return ST_SERVO2;
                        4: return ST_ESTOP;
                        default: return ST_CONNECTED;
                    endcase
            end
            return ST_UNKNOWN;
        endfunction

        function result_t decode_item(logic [11:0] batt, bit last);
            result_t     r;
            int unsigned m;
            int          v;
            int          duty;
            bit          sat;
            r = '0;
            r.frame_end = last;
            m = magnitude;
            sat = 1'b0;
            if (!colon_seen) begin
                r.status = ST_MALFORMED;
                return r;
            end
            r.status = match_name();
            if (negative) begin
                if (m > 32768) begin
                    m = 32768;
                    sat = 1'b1;
                end
                v = -int'(m);
            end else begin
                if (m > 32767) begin
                    m = 32767;
                    sat = 1'b1;
                end
                v = int'(m);
            end
            case (r.status)
                ST_MOTOR1, ST_MOTOR2: begin
                    if (m < deadband)
                        v = 0;
                    if (v >= 0) begin
                        duty = v;
                        if (duty > 255) begin
                            duty = 255;
                            sat = 1'b1;
                        end
                    end else begin
                        r.motor_reverse = 1'b1;
                        duty = 255 + v;
                        if (duty < 0) begin
                            duty = 0;
                            sat = 1'b1;
                        end
                    end
                    r.motor_duty = duty[7:0];
                    r.value_saturated = sat;
                end
                ST_SERVO1, ST_SERVO2: begin
                    if (v < 0) begin
                        v = 0;
                        sat = 1'b1;
                    end
                    if (v > int'(servo_max)) begin
                        v = int'(servo_max);
                        sat = 1'b1;
                    end
                    r.servo_angle = v[7:0];
                    r.value_saturated = sat;
                end
                ST_ESTOP:
                    r.estop_on = (on_state == ON_EXACT);
                ST_CONNECTED:
                    r.battery_value = 17'((int'(batt) * 45) / 2);
                default: ;
            endcase
            return r;
        endfunction

        function void value_byte(logic [7:0] c);
            bit          digit;
            int unsigned acc;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            case (on_state)
                ON_NONE: on_state = (c == CH_O) ? ON_O : ON_NOT;
                ON_O:    on_state = (c == CH_N) ? ON_EXACT : ON_NOT;
                default: on_state = ON_NOT;
            endcase
            if (phase == PH_SPACE) begin
                // space, tab, newline, vertical tab, form feed, carriage return
                if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))
                    return;
                if (c == CH_PLUS || c == CH_MINUS) begin
                    negative = (c == CH_MINUS);
                    phase = PH_SIGN;
                    return;
                end
                phase = digit ? PH_DIGITS : PH_DONE;
            end else if (phase == PH_SIGN) begin
                phase = digit ? PH_DIGITS : PH_DONE;
            end else if (phase == PH_DIGITS && !digit) begin
                phase = PH_DONE;
            end
            if (phase == PH_DIGITS) begin
                acc = magnitude * 10 + int'(c - CH_ZERO);
                magnitude = (acc > 65535) ? 65535 : acc;
            end
        endfunction

        // called for every byte the block accepts
        function void note_byte(logic [7:0] c, logic [11:0] batt);
            if (c == CH_CLOSE) begin
                awaited_items.push_back(decode_item(batt, 1'b1));
                clear_item();
                at_start = 1'b1;
                return;
            end
            if (at_start) begin
                at_start = 1'b0;
                return;
            end
            if (c == CH_COMMA) begin
                awaited_items.push_back(decode_item(batt, 1'b0));
                clear_item();
                return;
            end
            if (!colon_seen) begin
                if (c == CH_COLON) begin
                    colon_seen = 1'b1;
                end else begin
                    if (name_len < NAME_MAX)
                        name_buf[name_len] = c;
                    if (name_len <= NAME_MAX)
                        name_len++;
                end
                return;
            end
            value_byte(c);
        endfunction

        function string show(result_t r);
            return $sformatf("%s rev %0d duty %0d angle %0d estop %0d batt %0d sat %0d end %0d",
                r.status.name(), r.motor_reverse, r.motor_duty, r.servo_angle,
                r.estop_on, r.battery_value, r.value_saturated, r.frame_end);
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // called for every item the block hands out
        function void check_item(result_t got);
            result_t want;
            if (awaited_items.size() == 0) begin
                flag_error($sformatf("unexpected item: %s", show(got)));
                return;
            end
            want = awaited_items.pop_front();
            if (got.status !== want.status || got.motor_reverse !== want.motor_reverse ||
                got.motor_duty !== want.motor_duty || got.servo_angle !== want.servo_angle ||
                got.estop_on !== want.estop_on || got.battery_value !== want.battery_value ||
                got.value_saturated !== want.value_saturated ||
                got.frame_end !== want.frame_end)
                flag_error($sformatf("expected %s, got %s", show(want), show(got)));
        endfunction

    endclass

endpackage

// ===== dv/tb_motor_command_frame_parser.sv =====
// ----------------------------------------------------------------------------
// tb_motor_command_frame_parser
// Feeds directed and random command frames byte by byte, with random gaps
// and output stalls, under several deadband and servo limit settings, and
// checks every decoded item against the byte-level decoder.
// ----------------------------------------------------------------------------
module tb_motor_command_frame_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import mcfp_pkg::*;
    import mcfp_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 850;
    localparam int NUM_PHASES   = 6;
    localparam logic [7:0] CH_OPEN = 8'h5B;  // '['

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic [7:0]          rx_byte        = 8'h00;
    logic [11:0]         battery_sample = 12'h000;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [2:0]          status;
    logic                motor_reverse;
    logic [7:0]          motor_duty;
    logic [7:0]          servo_angle;
    logic                estop_on;
    logic [16:0]         battery_value;
    logic                value_saturated;
    logic                frame_end;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    frame_scoreboard     sb;
    result_t             dut_item;
    int unsigned         cycles         = 0;
    int unsigned         in_idle_pct    = 30;
    int unsigned         out_idle_pct   = 30;
    logic [7:0]          frame_bytes [$];
    string               cmd_names [6]  = '{"M1", "M2", "S1", "S2", "estop", "connected"};

    motor_command_frame_parser u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .battery_sample  (battery_sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .motor_reverse   (motor_reverse),
        .motor_duty      (motor_duty),
        .servo_angle     (servo_angle),
        .estop_on        (estop_on),
        .battery_value   (battery_value),
        .value_saturated (value_saturated),
        .frame_end       (frame_end),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #6 clk = ~clk;

    assign dut_item = {status, motor_reverse, motor_duty, servo_angle, estop_on,
                       battery_value, value_saturated, frame_end};

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_item(dut_item);
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [11:0] batt);
        @(negedge clk);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        rx_byte        <= b;
        battery_sample <= batt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, batt);
    endtask

    task automatic send_text(input string s, input logic [11:0] batt);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], batt);
    endtask

    // lets every pending item come out before registers change
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.awaited_items.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= {24'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_COLON || c == CH_COMMA || c == CH_CLOSE);
        return c;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_bytes.push_back(s[i]);
    endtask

    task automatic add_value(input bit is_estop);
        int unsigned mag;
        int          r;
        r = $urandom_range(0, 99);
        if (is_estop && r < 60) begin
            case ($urandom_range(0, 5))
                3: push_text("o");
                4: push_text("onn");
                5: push_text(" on");
                default: push_text("on");
            endcase
            return;
        end
        repeat ($urandom_range(0, 2))
            frame_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE
                                                              : 8'($urandom_range(9, 13)));
        case ($urandom_range(0, 7))
            0: frame_bytes.push_back(CH_PLUS);
            1, 2: frame_bytes.push_back(CH_MINUS);
            3: begin
                frame_bytes.push_back(CH_PLUS);
                frame_bytes.push_back(CH_MINUS);
            end
            default: ;
        endcase
        if (r < 95) begin
            case ($urandom_range(0, 6))
                0: mag = $urandom_range(0, 12);
                1, 2: mag = $urandom_range(0, 300);
                3: mag = $urandom_range(0, 2000);
                4: mag = $urandom_range(32760, 32775);
                5: mag = $urandom_range(65530, 65545);
                default: mag = $urandom;
            endcase
            if ($urandom_range(0, 9) == 0)
                push_text("00");
            push_text($sformatf("%0d", mag));
        end
        // trailing junk stops the number unless it is a digit
        if ($urandom_range(0, 4) == 0) begin
            frame_bytes.push_back(name_char());
            if ($urandom_range(0, 1))
                push_text($sformatf("%0d", $urandom_range(0, 99)));
        end
    endtask

    task automatic add_item();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            k = $urandom_range(0, 5);
            push_text(cmd_names[k]);
            frame_bytes.push_back(CH_COLON);
            add_value(k == 4);
        end else if (r < 68) begin
            // near miss of a known name
            push_text(cmd_names[$urandom_range(0, 5)]);
            if ($urandom_range(0, 1))
                frame_bytes.push_back(name_char());
            else
                frame_bytes[frame_bytes.size() - 1] = name_char();
            frame_bytes.push_back(CH_COLON);
            add_value(1'b1);
        end else if (r < 76) begin
            repeat ($urandom_range(0, 12))
                frame_bytes.push_back(name_char());
            frame_bytes.push_back(CH_COLON);
            add_value(1'b0);
        end else if (r < 86) begin
            // no colon at all
            repeat ($urandom_range(0, 5))
                frame_bytes.push_back(name_char());
        end else if (r < 92) begin
            repeat ($urandom_range(NAME_MAX + 1, NAME_MAX + 5))
                frame_bytes.push_back(name_char());
            frame_bytes.push_back(CH_COLON);
            add_value(1'b0);
        end else begin
            repeat ($urandom_range(1, 6))
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_frame();
        int r;
        frame_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 5) begin
            frame_bytes.push_back(CH_CLOSE);
            return;
        end
        frame_bytes.push_back((r < 90) ? CH_OPEN : name_char());
        for (int i = 0; i < $urandom_range(1, 4); i++) begin
            if (i > 0)
                frame_bytes.push_back(CH_COMMA);
            add_item();
        end
        frame_bytes.push_back(CH_CLOSE);
    endtask

    task automatic send_frame();
        logic [11:0] batt;
        foreach (frame_bytes[i]) begin
            case ($urandom_range(0, 7))
                0: batt = 12'h000;
                1: batt = 12'hFFF;
                default: batt = 12'($urandom);
            endcase
            send_byte(frame_bytes[i], batt);
        end
    endtask

    initial
    begin
        int sent;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // bracket as first byte, reverse underflow, empty item, negative angle
        send_text("]", 12'hFFF);
        send_text("[M2:-300,,S1:-9]", 12'h000);
        send_text("xestop:on,connected:]", 12'hFFF);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_until_drained();
                case (ph)
                    1: begin
                        write_reg(REG_DEADBAND, 8'd0);
                        write_reg(REG_SERVO_MAX, 8'd255);
                    end
                    2: begin
                        write_reg(REG_DEADBAND, 8'd255);
                        write_reg(REG_SERVO_MAX, 8'd0);
                    end
                    4: begin
                        write_reg(REG_DEADBAND, 8'd20);
                        write_reg(REG_SERVO_MAX, 8'd90);
                    end
                    default: begin
                        write_reg(REG_DEADBAND, 8'($urandom_range(0, 255)));
                        write_reg(REG_SERVO_MAX, 8'($urandom_range(0, 255)));
                    end
                endcase
            end
            // phase 3 runs with both sides always ready
            in_idle_pct  = (ph == 3) ? 0 : 30;
            out_idle_pct = (ph == 3) ? 0 : 30;
            sent = 0;
            while (sent < RANDOM_BYTES / NUM_PHASES) begin
                build_frame();
                sent += frame_bytes.size();
                send_frame();
            end
        end

        wait_until_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.awaited_items.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
